/* hdl/stm_pkg.sv */
// stm_pkg: shared types and default sizes for the sparse triplet merge adder
// used by sparse_triplet_merge_add, stm_checker and the test; depends on nothing

package stm_pkg;

    // default sizes, handed to the top level parameters
    localparam int LIST_DEPTH_DEF = 32;
    localparam int COORD_BITS_DEF = 10;
    localparam int VALUE_BITS_DEF = 16;

    // input command codes, code three is unused and ignored
    typedef enum logic [1:0] {
        CMD_LOAD_A = 2'd0,
        CMD_LOAD_B = 2'd1,
        CMD_MERGE  = 2'd2
    } t_cmd;

    // merge sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_FIN
    } t_state;

endpackage

/* hdl/stm_ram.sv */
// stm_ram: generic single write port, single read port ram with registered read
// no dependencies

module stm_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/sparse_triplet_merge_add.sv */
// Sparse triplet merge adder. Load words (command 0 or 1) append a (row, col, value)
// triplet to list A or list B and are taken one per cycle while the block is idle;
// a load into a full list is dropped and sets a sticky overflow flag, cleared only by
// reset. A merge word (command 2) walks both lists in row-major coordinate order with
// one shared compare-and-add unit: each step reads one entry of each list from its
// ram (registered read) in ST_READ and compares or adds them in ST_CMP; a step
// can wait while the output is stalled, and the input stays busy until the final
// word of the merge is issued.
// Matching coordinates are summed and dropped when the sum is zero. One result is
// held back so the final word can carry is_last; a sum with no entries gives one word
// with is_empty and is_last set. Both lists are empty after the merge. Input ready is
// high only while idle; command 3 is accepted and ignored.
// depends on stm_pkg and stm_ram

module sparse_triplet_merge_add #(
    parameter int LIST_DEPTH = stm_pkg::LIST_DEPTH_DEF,
    parameter int COORD_BITS = stm_pkg::COORD_BITS_DEF,
    parameter int VALUE_BITS = stm_pkg::VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_command,
    input  logic [COORD_BITS-1:0]        i_row_index,
    input  logic [COORD_BITS-1:0]        i_col_index,
    input  logic signed [VALUE_BITS-1:0] i_entry_value,
    // output channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [COORD_BITS-1:0]        o_out_row,
    output logic [COORD_BITS-1:0]        o_out_col,
    output logic signed [VALUE_BITS:0]   o_out_value,
    output logic                         o_is_last,
    output logic                         o_is_empty,
    output logic                         o_overflowed
);

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int KW = 2 * COORD_BITS;
    localparam int EW = KW + VALUE_BITS;
    localparam int OW = VALUE_BITS + 1;

    stm_pkg::t_state r_state, n_state;

    logic [CW-1:0]         r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b;
    logic [CW-1:0]         r_ia, n_ia, r_ib, n_ib;
    logic                  r_ovf, n_ovf;
    logic                  r_pend_valid, n_pend_valid;
    logic [COORD_BITS-1:0] r_pend_row, n_pend_row, r_pend_col, n_pend_col;
    logic [OW-1:0]         r_pend_val, n_pend_val;
    logic                  r_out_valid, n_out_valid;
    logic [COORD_BITS-1:0] r_out_row, n_out_row, r_out_col, n_out_col;
    logic [OW-1:0]         r_out_val, n_out_val;
    logic                  r_out_last, n_out_last;
    logic                  r_out_empty, n_out_empty;
    logic                  r_out_ovf, n_out_ovf;

    logic          in_acc, we_a, we_b, full_a, full_b;
    logic [EW-1:0] wdata, rd_a, rd_b;
    logic          a_ok, b_ok, key_eq, key_lt, take_a, take_b, both, cand_emit, out_free;
    logic [KW-1:0] key_a, key_b;
    logic [OW-1:0] ext_a, ext_b, sum_ab, cand_val;
    logic [COORD_BITS-1:0] cand_row, cand_col;

    // load decode
    assign in_acc = i_in_valid && o_in_ready;
    assign full_a = (r_cnt_a >= CW'(LIST_DEPTH));
    assign full_b = (r_cnt_b >= CW'(LIST_DEPTH));
    assign we_a   = in_acc && (i_command == stm_pkg::CMD_LOAD_A) && !full_a;
    assign we_b   = in_acc && (i_command == stm_pkg::CMD_LOAD_B) && !full_b;
    assign wdata  = {i_row_index, i_col_index, i_entry_value};

    // list storage, read address follows the merge indexes
    stm_ram #(.WIDTH(EW), .DEPTH(LIST_DEPTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_cnt_a[AW-1:0]),
        .i_wdata (wdata),
        .i_raddr (r_ia[AW-1:0]),
        .o_rdata (rd_a)
    );

    stm_ram #(.WIDTH(EW), .DEPTH(LIST_DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_cnt_b[AW-1:0]),
        .i_wdata (wdata),
        .i_raddr (r_ib[AW-1:0]),
        .o_rdata (rd_b)
    );

    // shared compare and add unit
    assign a_ok   = (r_ia < r_cnt_a);
    assign b_ok   = (r_ib < r_cnt_b);
    assign key_a  = rd_a[EW-1:VALUE_BITS];
    assign key_b  = rd_b[EW-1:VALUE_BITS];
    assign key_eq = (key_a == key_b);
    assign key_lt = (key_a < key_b);
    assign take_a = a_ok && (!b_ok || key_lt || key_eq);
    assign take_b = b_ok && (!a_ok || !key_lt);
    assign both   = take_a && take_b;
    assign ext_a  = {rd_a[VALUE_BITS-1], rd_a[VALUE_BITS-1:0]};
    assign ext_b  = {rd_b[VALUE_BITS-1], rd_b[VALUE_BITS-1:0]};
    assign sum_ab = ext_a + ext_b;

    always_comb begin
        if (both) begin
            cand_val = sum_ab;
        end else if (take_a) begin
            cand_val = ext_a;
        end else begin
            cand_val = ext_b;
        end
        if (take_a) begin
            cand_row = rd_a[EW-1:EW-COORD_BITS];
            cand_col = rd_a[KW-1+VALUE_BITS-COORD_BITS:VALUE_BITS];
        end else begin
            cand_row = rd_b[EW-1:EW-COORD_BITS];
            cand_col = rd_b[KW-1+VALUE_BITS-COORD_BITS:VALUE_BITS];
        end
    end

    assign cand_emit = !(both && (sum_ab == '0));
    assign out_free  = !r_out_valid || i_out_ready;

    // state and data registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= stm_pkg::ST_IDLE;
            r_cnt_a      <= '0;
            r_cnt_b      <= '0;
            r_ia         <= '0;
            r_ib         <= '0;
            r_ovf        <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt_a      <= n_cnt_a;
            r_cnt_b      <= n_cnt_b;
            r_ia         <= n_ia;
            r_ib         <= n_ib;
            r_ovf        <= n_ovf;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
        r_pend_row  <= n_pend_row;
        r_pend_col  <= n_pend_col;
        r_pend_val  <= n_pend_val;
        r_out_row   <= n_out_row;
        r_out_col   <= n_out_col;
        r_out_val   <= n_out_val;
        r_out_last  <= n_out_last;
        r_out_empty <= n_out_empty;
        r_out_ovf   <= n_out_ovf;
    end

    // merge sequencer
    always_comb begin
        n_state      = r_state;
        n_cnt_a      = r_cnt_a;
        n_cnt_b      = r_cnt_b;
        n_ia         = r_ia;
        n_ib         = r_ib;
        n_ovf        = r_ovf;
        n_pend_valid = r_pend_valid;
        n_pend_row   = r_pend_row;
        n_pend_col   = r_pend_col;
        n_pend_val   = r_pend_val;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_row    = r_out_row;
        n_out_col    = r_out_col;
        n_out_val    = r_out_val;
        n_out_last   = r_out_last;
        n_out_empty  = r_out_empty;
        n_out_ovf    = r_out_ovf;
        o_in_ready   = 1'b0;

        unique case (r_state)
            stm_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (in_acc) begin
                    if (i_command == stm_pkg::CMD_LOAD_A) begin
                        if (full_a) n_ovf = 1'b1;
                        else        n_cnt_a = r_cnt_a + 1'b1;
                    end else if (i_command == stm_pkg::CMD_LOAD_B) begin
                        if (full_b) n_ovf = 1'b1;
                        else        n_cnt_b = r_cnt_b + 1'b1;
                    end else if (i_command == stm_pkg::CMD_MERGE) begin
                        n_ia         = '0;
                        n_ib         = '0;
                        n_pend_valid = 1'b0;
                        n_state      = stm_pkg::ST_READ;
                    end
                end
            end
            stm_pkg::ST_READ: begin
                // ram read of both heads in flight
                n_state = stm_pkg::ST_CMP;
            end
            stm_pkg::ST_CMP: begin
                if (!a_ok && !b_ok) begin
                    n_state = stm_pkg::ST_FIN;
                end else if (!(cand_emit && r_pend_valid && !out_free)) begin
                    if (cand_emit) begin
                        // push the held word, hold the new one
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out_row   = r_pend_row;
                            n_out_col   = r_pend_col;
                            n_out_val   = r_pend_val;
                            n_out_last  = 1'b0;
                            n_out_empty = 1'b0;
                            n_out_ovf   = r_ovf;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_row   = cand_row;
                        n_pend_col   = cand_col;
                        n_pend_val   = cand_val;
                    end
                    if (take_a) n_ia = r_ia + 1'b1;
                    if (take_b) n_ib = r_ib + 1'b1;
                    n_state = stm_pkg::ST_READ;
                end
            end
            stm_pkg::ST_FIN: begin
                // final word, or the empty marker
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_last   = 1'b1;
                    n_out_ovf    = r_ovf;
                    n_out_empty  = !r_pend_valid;
                    n_out_row    = r_pend_valid ? r_pend_row : '0;
                    n_out_col    = r_pend_valid ? r_pend_col : '0;
                    n_out_val    = r_pend_valid ? r_pend_val : '0;
                    n_pend_valid = 1'b0;
                    n_cnt_a      = '0;
                    n_cnt_b      = '0;
                    n_state      = stm_pkg::ST_IDLE;
                end
            end
            default: n_state = stm_pkg::ST_IDLE;
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_row    = r_out_row;
    assign o_out_col    = r_out_col;
    assign o_out_value  = r_out_val;
    assign o_is_last    = r_out_last;
    assign o_is_empty   = r_out_empty;
    assign o_overflowed = r_out_ovf;

endmodule

/* hdl/stm_checker.sv */
// stm_checker: port-level assertions for sparse_triplet_merge_add, with its bind
// depends on stm_pkg and the top level's ports

module stm_checker #(
    parameter int COORD_BITS = stm_pkg::COORD_BITS_DEF,
    parameter int VALUE_BITS = stm_pkg::VALUE_BITS_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic [1:0]                   i_command,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [COORD_BITS-1:0]        o_out_row,
    input logic [COORD_BITS-1:0]        o_out_col,
    input logic signed [VALUE_BITS:0]   o_out_value,
    input logic                         o_is_last,
    input logic                         o_is_empty,
    input logic                         o_overflowed
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_row)
            && $stable(o_out_col) && $stable(o_out_value) && $stable(o_is_last))
        else $error("stalled output word changed");

    // empty marker is the last word and carries zeros
    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_empty |-> o_is_last && o_out_row == '0
            && o_out_col == '0 && o_out_value == '0)
        else $error("empty marker malformed");

    // a merge word makes the block busy
    a_merge_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_command == stm_pkg::CMD_MERGE |=> !o_in_ready)
        else $error("ready stayed high after a merge word");

    // overflow is sticky between reset
    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && $past(o_out_valid) && $past(o_overflowed) && $past(i_rst_n)
            |-> o_overflowed)
        else $error("overflow flag dropped");

endmodule

bind sparse_triplet_merge_add stm_checker #(
    .COORD_BITS (COORD_BITS),
    .VALUE_BITS (VALUE_BITS)
) u_stm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_command    (i_command),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_out_row    (o_out_row),
    .o_out_col    (o_out_col),
    .o_out_value  (o_out_value),
    .o_is_last    (o_is_last),
    .o_is_empty   (o_is_empty),
    .o_overflowed (o_overflowed)
);

/* dv/sparse_triplet_merge_add_test.sv */
// sparse_triplet_merge_add_test: stimulus, sum predictor and result checker for the merge adder
// drives load and merge words in bursts against a stalling receiver; depends on stm_pkg and sparse_triplet_merge_add
`timescale 1ns / 1ps

module sparse_triplet_merge_add_test;

    localparam int DEPTH       = stm_pkg::LIST_DEPTH_DEF;
    localparam int CB          = stm_pkg::COORD_BITS_DEF;
    localparam int VB          = stm_pkg::VALUE_BITS_DEF;
    localparam int KEY_BITS    = 2 * CB;
    localparam int KEY_MAX     = (1 << KEY_BITS) - 1;
    localparam int ITEM_TARGET = 380;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_WAIT  = 40;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DIRECTED_ROWS = 25;

    // command code three is outside the package enum
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [CB-1:0] row;
        logic [CB-1:0] col;
        logic [VB-1:0] value;
    } t_triplet;

    typedef struct packed {
        logic [CB-1:0] row;
        logic [CB-1:0] col;
        logic [VB:0]   value;
        logic          last;
        logic          empty;
        logic          ovf;
    } t_sum_word;

    typedef struct packed {
        logic [1:0]    cmd;
        logic [CB-1:0] row;
        logic [CB-1:0] col;
        logic [VB-1:0] value;
        logic          typed;
        t_sum_word     want;
    } t_cmd_word;

    localparam t_sum_word NONE = '0;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_in_valid = 1'b0;
    logic          o_in_ready;
    logic [1:0]    i_command = stm_pkg::CMD_LOAD_A;
    logic [CB-1:0] i_row_index = '0;
    logic [CB-1:0] i_col_index = '0;
    logic [VB-1:0] i_entry_value = '0;
    logic          o_out_valid;
    logic          i_out_ready = 1'b0;
    logic [CB-1:0] o_out_row;
    logic [CB-1:0] o_out_col;
    logic [VB:0]   o_out_value;
    logic          o_is_last;
    logic          o_is_empty;
    logic          o_overflowed;

    // predictor state
    t_triplet  list_a [DEPTH];
    t_triplet  list_b [DEPTH];
    int        count_a = 0;
    int        count_b = 0;
    logic      ovf_seen = 1'b0;

    t_cmd_word cmd_words [$];
    t_sum_word sum_words_due [$];
    int        accepted_words = 0;
    int        words_checked = 0;
    int        mismatches = 0;
    int        cycle_count = 0;

    // directed words: extremes, cancellation, zero value, unsorted lists, unused command
    t_cmd_word directed_rows [DIRECTED_ROWS] = '{
        '{stm_pkg::CMD_MERGE,  10'd0,    10'd0,    16'h0000, 1'b1,
          '{10'd0, 10'd0, 17'h00000, 1'b1, 1'b1, 1'b0}},
        '{CMD_UNUSED,          10'd1023, 10'd1023, 16'hFFFF, 1'b0, NONE},
        '{stm_pkg::CMD_LOAD_A, 10'd0,    10'd0,    16'h7FFF, 1'b0, NONE},
        '{stm_pkg::CMD_LOAD_B, 10'd0,    10'd0,    16'h8001, 1'b0, NONE},
        '{stm_pkg::CMD_MERGE,  10'd0,    10'd0,    16'h0000, 1'b1,
          '{10'd0, 10'd0, 17'h00000, 1'b1, 1'b1, 1'b0}},
        '{stm_pkg::CMD_LOAD_A, 10'd1023, 10'd1023, 16'h8000, 1'b0, NONE},
        '{stm_pkg::CMD_LOAD_B, 10'd1023, 10'd1023, 16'h8000, 1'b0, NONE},
        '{stm_pkg::CMD_MERGE,  10'd1023, 10'd1023, 16'hFFFF, 1'b1,
          '{10'd1023, 10'd1023, 17'h10000, 1'b1, 1'b0, 1'b0}},
        '{stm_pkg::CMD_LOAD_A, 10'd0,    10'd0,    16'h7FFF, 1'b0, NONE},
        '{stm_pkg::CMD_LOAD_B, 10'd0,    10'd0,    16'h7FFF, 1'b0, NONE},
        '{stm_pkg::CMD_MERGE,  10'd0,    10'd0,    16'h0000, 1'b1,
          '{10'd0, 10'd0, 17'h0FFFE, 1'b1, 1'b0, 1'b0}},
        '{stm_pkg::CMD_LOAD_A, 10'd5,    10'd7,    16'h0000, 1'b0, NONE},
        '{stm_pkg::CMD_MERGE,  10'd0,    10'd0,    16'h0000, 1'b1,
          '{10'd5, 10'd7, 17'h00000, 1'b1, 1'b0, 1'b0}},
        '{stm_pkg::CMD_LOAD_A, 10'd0,    10'd1,    16'd100,  1'b0, NONE},
        '{stm_pkg::CMD_LOAD_A, 10'd3,    10'd0,    16'hFFFB, 1'b0, NONE},
        '{stm_pkg::CMD_LOAD_B, 10'd0,    10'd1023, 16'd9,    1'b0, NONE},
        '{stm_pkg::CMD_LOAD_B, 10'd3,    10'd0,    16'd5,    1'b0, NONE},
        '{stm_pkg::CMD_LOAD_B, 10'd1023, 10'd0,    16'd1,    1'b0, NONE},
        '{stm_pkg::CMD_MERGE,  10'd0,    10'd0,    16'h0000, 1'b0, NONE},
        '{stm_pkg::CMD_LOAD_A, 10'd9,    10'd9,    16'd1,    1'b0, NONE},
        '{stm_pkg::CMD_LOAD_A, 10'd2,    10'd2,    16'd2,    1'b0, NONE},
        '{stm_pkg::CMD_LOAD_B, 10'd5,    10'd5,    16'd3,    1'b0, NONE},
        '{stm_pkg::CMD_MERGE,  10'd0,    10'd0,    16'h0000, 1'b0, NONE},
        '{stm_pkg::CMD_LOAD_B, 10'd682,  10'd341,  16'h5555, 1'b0, NONE},
        '{stm_pkg::CMD_MERGE,  10'd0,    10'd0,    16'h0000, 1'b1,
          '{10'd682, 10'd341, 17'h05555, 1'b1, 1'b0, 1'b0}}
    };

    sparse_triplet_merge_add DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_row_index   (i_row_index),
        .i_col_index   (i_col_index),
        .i_entry_value (i_entry_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_out_value   (o_out_value),
        .o_is_last     (o_is_last),
        .o_is_empty    (o_is_empty),
        .o_overflowed  (o_overflowed)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // append to a list, or drop and flag when it is full
    function automatic void store_triplet(input bit to_b, input t_triplet t);
        if (to_b) begin
            if (count_b >= DEPTH) ovf_seen = 1'b1;
            else list_b[count_b++] = t;
        end else begin
            if (count_a >= DEPTH) ovf_seen = 1'b1;
            else list_a[count_a++] = t;
        end
    endfunction

    function automatic t_sum_word make_word(input t_triplet t, input logic [VB:0] value);
        t_sum_word w;
        w = '0;
        w.row   = t.row;
        w.col   = t.col;
        w.value = value;
        w.ovf   = ovf_seen;
        return w;
    endfunction

    // walk both lists in coordinate order, sum matches, drop zero sums
    function automatic void merge_sum_lists(input logic typed, input t_sum_word want);
        t_sum_word   words [$];
        int          ia;
        int          ib;
        logic signed [VB:0] sum;
        ia = 0;
        ib = 0;
        while (ia < count_a && ib < count_b) begin
            if ({list_a[ia].row, list_a[ia].col} == {list_b[ib].row, list_b[ib].col}) begin
                sum = $signed(list_a[ia].value) + $signed(list_b[ib].value);
                if (sum != 0) words.push_back(make_word(list_a[ia], sum));
                ia++;
                ib++;
            end else if ({list_a[ia].row, list_a[ia].col} < {list_b[ib].row, list_b[ib].col})
            begin
                words.push_back(make_word(list_a[ia], $signed(list_a[ia].value)));
                ia++;
            end else begin
                words.push_back(make_word(list_b[ib], $signed(list_b[ib].value)));
                ib++;
            end
        end
        for (; ia < count_a; ia++)
            words.push_back(make_word(list_a[ia], $signed(list_a[ia].value)));
        for (; ib < count_b; ib++)
            words.push_back(make_word(list_b[ib], $signed(list_b[ib].value)));
        // empty sum still answers with one marker word
        if (words.size() == 0) begin
            words.push_back(make_word('0, '0));
            words[0].empty = 1'b1;
        end
        words[words.size()-1].last = 1'b1;
        count_a = 0;
        count_b = 0;
        if (typed) sum_words_due.push_back(want);
        else foreach (words[i]) sum_words_due.push_back(words[i]);
    endfunction

    function automatic void absorb_word(input t_cmd_word w);
        t_triplet t;
        t = {w.row, w.col, w.value};
        case (w.cmd)
            stm_pkg::CMD_LOAD_A: store_triplet(1'b0, t);
            stm_pkg::CMD_LOAD_B: store_triplet(1'b1, t);
            stm_pkg::CMD_MERGE:  merge_sum_lists(w.typed, w.want);
            default: ;
        endcase
    endfunction

    function automatic void note_field(input string name, input longint want, input longint got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    function automatic void check_sum_word(input t_sum_word got);
        t_sum_word want;
        if (sum_words_due.size() == 0) begin
            mismatches++;
            $display("%0t: result word with nothing expected, expected none, actual %0d %0d %0d",
                     $time, got.row, got.col, $signed(got.value));
            return;
        end
        want = sum_words_due.pop_front();
        note_field("out_row", want.row, got.row);
        note_field("out_col", want.col, got.col);
        note_field("out_value", $signed(want.value), $signed(got.value));
        note_field("is_last", want.last, got.last);
        note_field("is_empty", want.empty, got.empty);
        note_field("overflowed", want.ovf, got.ovf);
    endfunction

    // watch both handshakes
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                absorb_word({i_command, i_row_index, i_col_index, i_entry_value,
                             cmd_words[accepted_words].typed, cmd_words[accepted_words].want});
                accepted_words <= accepted_words + 1;
            end
            if (o_out_valid && i_out_ready) begin
                check_sum_word({o_out_row, o_out_col, o_out_value,
                                o_is_last, o_is_empty, o_overflowed});
                words_checked <= words_checked + 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [VB-1:0] pick_value();
        case ($urandom_range(0, 19))
            0: return {1'b1, {(VB-1){1'b0}}};
            1: return {1'b0, {(VB-1){1'b1}}};
            2: return '0;
            3: return '1;
            default: return VB'($urandom);
        endcase
    endfunction

    function automatic void queue_word(input logic [1:0] cmd, input t_triplet t);
        cmd_words.push_back({cmd, t.row, t.col, t.value, 1'b0, NONE});
    endfunction

    // one load set for each list, then a merge word
    function automatic void queue_merge_set(input int want_a, input int want_b, input bit sorted);
        t_triplet part_a [$];
        t_triplet part_b [$];
        t_triplet t;
        int       key;
        int       stride_max;
        int       pick;
        key = ($urandom_range(0, 9) == 0) ? KEY_MAX - 200 : $urandom_range(0, 1000);
        stride_max = (KEY_MAX - key) / (want_a + want_b + 1);
        if (stride_max < 1) stride_max = 1;
        if (stride_max > 3 && $urandom_range(0, 1) == 0) stride_max = 3;
        while (part_a.size() < want_a || part_b.size() < want_b) begin
            if (!sorted && $urandom_range(0, 3) != 0) key = $urandom_range(0, KEY_MAX);
            t.row   = key[KEY_BITS-1:CB];
            t.col   = key[CB-1:0];
            t.value = pick_value();
            pick = $urandom_range(0, 99);
            if (part_a.size() >= want_a) pick = 50;
            else if (part_b.size() >= want_b) pick = 0;
            if (pick < 35 || pick >= 70) part_a.push_back(t);
            if (pick >= 35) begin
                // shared coordinate: often the exact negative so the sum cancels
                if (pick >= 70) t.value = ($urandom_range(0, 2) == 0) ? -t.value : pick_value();
                part_b.push_back(t);
            end
            if (sorted) key += $urandom_range(1, stride_max);
        end
        // interleave the two lists, with the odd unused command thrown in
        while (part_a.size() + part_b.size() > 0) begin
            if (part_b.size() == 0 || (part_a.size() != 0 && $urandom_range(0, 1) == 1))
                queue_word(stm_pkg::CMD_LOAD_A, part_a.pop_front());
            else
                queue_word(stm_pkg::CMD_LOAD_B, part_b.pop_front());
            if ($urandom_range(0, 14) == 0)
                queue_word(CMD_UNUSED, {CB'($urandom), CB'($urandom), VB'($urandom)});
        end
        queue_word(stm_pkg::CMD_MERGE, {CB'($urandom), CB'($urandom), VB'($urandom)});
    endfunction

    // sender: bursts of words with random gaps, payload held until taken
    task automatic send_words();
        int idx;
        int burst_left;
        int gap_left;
        idx = 0;
        burst_left = 0;
        gap_left = 0;
        while (idx < cmd_words.size()) begin
            @(posedge i_clk);
            if (i_in_valid && o_in_ready) idx++;
            if (i_in_valid && !o_in_ready) continue;
            if (idx < cmd_words.size() && gap_left == 0) begin
                i_command     <= cmd_words[idx].cmd;
                i_row_index   <= cmd_words[idx].row;
                i_col_index   <= cmd_words[idx].col;
                i_entry_value <= cmd_words[idx].value;
                i_in_valid    <= 1'b1;
                if (burst_left == 0)
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                            : $urandom_range(1, 12);
                burst_left--;
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
                i_in_valid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end
        end
    endtask

    // receiver: stall pattern changes every phase, plus one long hold-off
    initial begin : take_side
        int  mode;
        int  phase_len;
        int  tick;
        bit  long_hold_done;
        tick = 0;
        long_hold_done = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            phase_len = $urandom_range(20, 120);
            repeat (phase_len) begin
                @(posedge i_clk);
                tick++;
                if (!long_hold_done && words_checked >= 40) begin
                    long_hold_done = 1'b1;
                    i_out_ready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge i_clk);
                end
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= ($urandom_range(0, 3) != 0);
                    2: i_out_ready <= (tick % 3 != 0);
                    default: i_out_ready <= $urandom_range(0, 1);
                endcase
            end
        end
    end

    initial begin : run
        int  r;
        bit  overflow_done;
        overflow_done = 1'b0;
        foreach (directed_rows[i]) cmd_words.push_back(directed_rows[i]);
        // random merge sets, mostly sorted with small lists
        while (cmd_words.size() < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (!overflow_done && cmd_words.size() > ITEM_TARGET / 2) begin
                queue_merge_set(DEPTH + 2, DEPTH + 1, 1'b1);
                overflow_done = 1'b1;
            end else if (r < 8) begin
                queue_merge_set($urandom_range(9, DEPTH), $urandom_range(9, DEPTH), 1'b1);
            end else if (r < 20) begin
                queue_merge_set($urandom_range(0, 6), $urandom_range(0, 6), 1'b0);
            end else if (r < 25) begin
                queue_merge_set(0, 0, 1'b1);
            end else begin
                queue_merge_set($urandom_range(0, 8), $urandom_range(0, 8), 1'b1);
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_words();
        @(posedge i_clk);
        while (sum_words_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0 && sum_words_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
